FILE: design/vsea_pkg.sv
// Shared constants and controller/datapath interface types for the vector aggregate block.
`timescale 1ns / 1ps
package vsea_pkg;

    localparam int DEF_MAX_VECTORS  = 32;
    localparam int DEF_MAX_LENGTH   = 64;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam int POS_W = 6;
    localparam int LEN_W = 7;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    localparam logic MODE_MEDIAN = 1'b0;
    localparam logic MODE_MEAN   = 1'b1;

    // Register index as decoded from paddr[2]
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    typedef struct packed {
        logic we;        // store the incoming element
        logic re;        // read the store
        logic cand_ld;   // latch read data as median candidate
        logic cnt_upd;   // rank the read data against the candidate
        logic sum_add;   // accumulate read data
        logic first;     // first vector of a scan: restart counts or sum
        logic div_start; // start the mean division
        logic out_ld;    // load the output register
        logic mean;      // output register takes the quotient
        logic last;      // final position of the vector
        logic ovf;       // vectors were dropped in this set
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic hit;
    } t_dp_sts;

endpackage

FILE: design/vsea_div.sv
// Iterative restoring divider, signed numerator by unsigned count, truncating toward zero.
`timescale 1ns / 1ps
module vsea_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   n_rem_sh;
    logic             n_fit;

    always_comb begin
        n_rem_sh = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        n_fit    = n_rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_quo <= i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_fit ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
            r_quo <= {r_quo[NUM_W-2:0], n_fit};
        end
    end

    assign o_done = r_busy && (r_cnt == CNT_W'(1));
    assign o_quot = r_neg ? $signed(~r_quo + 1'b1) : $signed(r_quo);

endmodule

FILE: design/vsea_datapath.sv
// Element store, rank counters, sum accumulator, divider and output register.
`timescale 1ns / 1ps
module vsea_datapath
    import vsea_pkg::*;
#(
    parameter int MAX_VECTORS  = DEF_MAX_VECTORS,
    parameter int MAX_LENGTH   = DEF_MAX_LENGTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    output t_dp_sts                        o_sts,
    input  logic [$clog2(MAX_VECTORS+1)-1:0] i_n,
    input  logic [((MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1)
                 + ((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1) - 1:0] i_addr,
    input  logic signed [SAMPLE_WIDTH-1:0] i_wdata,
    input  logic [POS_W-1:0]               i_out_pos,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_result_value,
    output logic [POS_W-1:0]               o_position,
    output logic                           o_last_of_vector,
    output logic                           o_dropped_vectors
);

    localparam int VW    = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int PW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int AW    = VW + PW;
    localparam int DEPTH = MAX_VECTORS * (2 ** PW);
    localparam int CW    = $clog2(MAX_VECTORS + 1);
    localparam int SUMW  = SAMPLE_WIDTH + CW;

    logic signed [SAMPLE_WIDTH-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_rdata;
    logic signed [SAMPLE_WIDTH-1:0] r_cand;
    logic        [CW-1:0]           r_less;
    logic        [CW-1:0]           r_equal;
    logic signed [SUMW-1:0]         r_sum;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_value;
    logic        [POS_W-1:0]        r_out_pos;
    logic                           r_out_last;
    logic                           r_out_ovf;

    logic                           n_div_done;
    logic signed [SUMW-1:0]         n_quot;
    logic        [CW:0]             n_rank;
    logic        [CW:0]             n_upper;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cand_ld) begin
            r_cand <= r_rdata;
        end
        if (i_cmd.cnt_upd) begin
            r_less  <= (i_cmd.first ? '0 : r_less)  + CW'(r_rdata < r_cand);
            r_equal <= (i_cmd.first ? '0 : r_equal) + CW'(r_rdata == r_cand);
        end
        if (i_cmd.sum_add) begin
            r_sum <= (i_cmd.first ? '0 : r_sum) + SUMW'(r_rdata);
        end
    end

    vsea_div #(
        .NUM_W (SUMW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_sum),
        .i_den   (i_n),
        .o_done  (n_div_done),
        .o_quot  (n_quot)
    );

    // Candidate holds the middle rank when it lies within its run of equals
    always_comb begin
        n_rank  = {1'b0, i_n} >> 1;
        n_upper = {1'b0, r_less} + {1'b0, r_equal};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_value <= i_cmd.mean ? n_quot[SAMPLE_WIDTH-1:0] : r_cand;
            r_out_pos   <= i_out_pos;
            r_out_last  <= i_cmd.last;
            r_out_ovf   <= i_cmd.ovf;
        end
    end

    assign o_sts.div_done = n_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.hit      = (i_n <= CW'(2))
                         || (({1'b0, r_less} <= n_rank) && (n_rank < n_upper));

    assign o_out_valid       = r_out_valid;
    assign o_result_value    = r_out_value;
    assign o_position        = r_out_pos;
    assign o_last_of_vector  = r_out_last;
    assign o_dropped_vectors = r_out_ovf;

endmodule

FILE: design/vsea_ctrl.sv
// Controller: load sequencing, per-position median search and mean scan, result issue.
`timescale 1ns / 1ps
module vsea_ctrl
    import vsea_pkg::*;
#(
    parameter int MAX_VECTORS = DEF_MAX_VECTORS,
    parameter int MAX_LENGTH  = DEF_MAX_LENGTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_end_of_set,
    input  logic                     i_mode,
    input  logic [LEN_W-1:0]         i_len,
    output t_dp_cmd                  o_cmd,
    input  t_dp_sts                  i_sts,
    output logic [$clog2(MAX_VECTORS+1)-1:0] o_n,
    output logic [((MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1)
                 + ((MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1) - 1:0] o_addr,
    output logic [POS_W-1:0]         o_out_pos
);

    localparam int VW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int PW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CW = $clog2(MAX_VECTORS + 1);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_CAND_RD  = 4'd1;
    localparam logic [3:0] S_CAND_LD  = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_USE = 4'd4;
    localparam logic [3:0] S_CHECK    = 4'd5;
    localparam logic [3:0] S_SUM_RD   = 4'd6;
    localparam logic [3:0] S_SUM_USE  = 4'd7;
    localparam logic [3:0] S_DIV_GO   = 4'd8;
    localparam logic [3:0] S_DIV      = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [PW-1:0] r_p, n_p;
    logic [VW-1:0] r_i, n_i;
    logic [VW-1:0] r_j, n_j;

    logic [PW-1:0] n_pos_c;
    logic          n_store;
    logic          n_last_elem;
    logic          n_last_pos;
    logic          n_last_vec;
    logic [3:0]    n_scan_state;

    always_comb begin
        // Clamp the element index when the length shrank mid-vector
        n_pos_c     = ({{(LEN_W-PW){1'b0}}, r_pos} >= i_len) ? PW'(i_len - 1'b1) : r_pos;
        n_store     = r_cnt < CW'(MAX_VECTORS);
        n_last_elem = ({1'b0, {(LEN_W-PW){1'b0}}, n_pos_c} + 1'b1) >= {1'b0, i_len};
        n_last_pos  = {{(LEN_W-PW){1'b0}}, r_p} == (i_len - 1'b1);
        n_last_vec  = CW'(r_j) == (r_cnt - 1'b1);
        n_scan_state = (i_mode == MODE_MEAN) ? S_SUM_RD : S_CAND_RD;
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_p     = r_p;
        n_i     = r_i;
        n_j     = r_j;
        o_cmd   = '0;
        o_addr  = {r_j, r_p};
        o_in_ready = 1'b0;
        o_cmd.mean = (i_mode == MODE_MEAN);
        o_cmd.last = n_last_pos;
        o_cmd.ovf  = r_ovf;
        o_cmd.first = (r_j == '0);

        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_addr     = {r_cnt[VW-1:0], n_pos_c};
                if (i_in_valid) begin
                    o_cmd.we = n_store;
                    if (!n_store) begin
                        n_ovf = 1'b1;
                    end
                    if (!n_last_elem) begin
                        n_pos = n_pos_c + 1'b1;
                    end else begin
                        n_pos = '0;
                        n_cnt = r_cnt + CW'(n_store);
                        if (i_end_of_set) begin
                            n_p     = '0;
                            n_i     = '0;
                            n_j     = '0;
                            n_state = n_scan_state;
                        end
                    end
                end
            end
            S_CAND_RD: begin
                o_cmd.re = 1'b1;
                o_addr   = {r_i, r_p};
                n_state  = S_CAND_LD;
            end
            S_CAND_LD: begin
                o_cmd.cand_ld = 1'b1;
                n_j     = '0;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.re = 1'b1;
                n_state  = S_SCAN_USE;
            end
            S_SCAN_USE: begin
                o_cmd.cnt_upd = 1'b1;
                if (n_last_vec) begin
                    n_state = S_CHECK;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_CHECK: begin
                if (i_sts.hit) begin
                    n_state = S_EMIT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CAND_RD;
                end
            end
            S_SUM_RD: begin
                o_cmd.re = 1'b1;
                n_state  = S_SUM_USE;
            end
            S_SUM_USE: begin
                o_cmd.sum_add = 1'b1;
                if (n_last_vec) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SUM_RD;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_i = '0;
                    n_j = '0;
                    if (n_last_pos) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_pos   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_p     = r_p + 1'b1;
                        n_state = n_scan_state;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_p     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_p     <= n_p;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign o_n       = r_cnt;
    assign o_out_pos = POS_W'(r_p);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_VECTORS))
        else $error("stored vector count beyond capacity");

    a_agg_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_cnt != '0))
        else $error("aggregation running over an empty set");

    a_pos_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> ({{(LEN_W-PW){1'b0}}, r_p} < i_len))
        else $error("output position beyond vector length");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_set_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_sts.out_free && n_last_pos) |=>
            (r_state == S_LOAD && r_cnt == '0 && !r_ovf))
        else $error("set state not cleared after final result");

endmodule

FILE: design/vector_set_elementwise_aggregate.sv
// Top level: configuration registers, controller and datapath of the vector aggregate.
`timescale 1ns / 1ps
// Collects a set of vectors one element per transfer (one element per cycle while
// loading) into a single-port store of MAX_VECTORS x MAX_LENGTH samples, then emits
// one aggregated vector. The aggregation phase holds off input: per position, median
// mode re-ranks each candidate against all n stored elements through the one store
// read port, and mean mode runs a sum scan, then a bit-per-cycle divider. The next
// set may start loading while the final result still waits in the output register.
module vector_set_elementwise_aggregate
    import vsea_pkg::*;
#(
    parameter int MAX_VECTORS  = DEF_MAX_VECTORS,
    parameter int MAX_LENGTH   = DEF_MAX_LENGTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_element_value,
    input  logic                           i_end_of_set,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_result_value,
    output logic [POS_W-1:0]               o_position,
    output logic                           o_last_of_vector,
    output logic                           o_dropped_vectors,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int VW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int PW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CW = $clog2(MAX_VECTORS + 1);

    logic             r_mode;
    logic [LEN_W-1:0] r_vlen;
    logic [LEN_W-1:0] n_len;

    t_dp_cmd          n_cmd;
    t_dp_sts          n_sts;
    logic [CW-1:0]    n_n;
    logic [VW+PW-1:0] n_addr;
    logic [POS_W-1:0] n_out_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MEDIAN;
            r_vlen <= LEN_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_MODE) begin
                r_mode <= pwdata[0];
            end else begin
                r_vlen <= pwdata[LEN_W-1:0];
            end
        end
    end

    // Zero acts as one, anything above capacity as the full length
    always_comb begin
        if (r_vlen == '0) begin
            n_len = LEN_W'(1);
        end else if (r_vlen > LEN_W'(MAX_LENGTH)) begin
            n_len = LEN_W'(MAX_LENGTH);
        end else begin
            n_len = r_vlen;
        end
    end

    assign prdata = (paddr[2] == REG_LENGTH) ? {{(32-LEN_W){1'b0}}, r_vlen}
                                             : {31'b0, r_mode};
    assign pready = 1'b1;

    vsea_ctrl #(
        .MAX_VECTORS (MAX_VECTORS),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_end_of_set (i_end_of_set),
        .i_mode       (r_mode),
        .i_len        (n_len),
        .o_cmd        (n_cmd),
        .i_sts        (n_sts),
        .o_n          (n_n),
        .o_addr       (n_addr),
        .o_out_pos    (n_out_pos)
    );

    vsea_datapath #(
        .MAX_VECTORS  (MAX_VECTORS),
        .MAX_LENGTH   (MAX_LENGTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (n_cmd),
        .o_sts             (n_sts),
        .i_n               (n_n),
        .i_addr            (n_addr),
        .i_wdata           (i_element_value),
        .i_out_pos         (n_out_pos),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result_value    (o_result_value),
        .o_position        (o_position),
        .o_last_of_vector  (o_last_of_vector),
        .o_dropped_vectors (o_dropped_vectors)
    );

endmodule
